@@ sv/fbfbm_pkg.sv @@
// Package: payload types, register indexes, attribute bits and helpers for the format selector.
package fbfbm_pkg;

	localparam int DEFAULT_MAX_CANDIDATES = 256;
	localparam int IDX_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int MISS_W = 5;
	localparam int COLOR_W = 18;
	localparam int EXTRA_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_WANT_RGB     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WANT_ADS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WANT_ACCUM   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WANT_AUX     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WANT_SAMPLES = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WANT_FLAGS   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DONT_CARE    = 3'd6;

	localparam int DC_RED     = 0;
	localparam int DC_GREEN   = 1;
	localparam int DC_BLUE    = 2;
	localparam int DC_ALPHA   = 3;
	localparam int DC_DEPTH   = 4;
	localparam int DC_STENCIL = 5;
	localparam int DC_ACCUM0  = 6;
	localparam int DC_SAMPLES = 10;

	localparam int FLAG_STEREO = 0;
	localparam int FLAG_SRGB   = 1;
	localparam int FLAG_DOUBLE = 2;

	localparam logic [23:0] RESET_WANT_RGB = 24'h080808;
	localparam logic [23:0] RESET_WANT_ADS = 24'h081808;

	typedef struct packed {
		logic [7:0]  red_bits;
		logic [7:0]  green_bits;
		logic [7:0]  blue_bits;
		logic [7:0]  alpha_bits;
		logic [7:0]  depth_bits;
		logic [7:0]  stencil_bits;
		logic [31:0] accum_bits;
		logic [3:0]  aux_buffers;
		logic [7:0]  sample_count;
		logic [2:0]  format_flags;
		logic        last;
	} fbfbm_in_t;

	typedef struct packed {
		logic [IDX_W-1:0] best_index;
		logic             found;
	} fbfbm_out_t;

	function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return 16'(d) * 16'(d);
	endfunction

endpackage

@@ sv/framebuffer_format_best_match_top.sv @@
// Top level: scores candidate framebuffer formats and reports the best match per list.
//
//  channel | signals                          | direction | moves
//  in      | in_valid, in_stall, in_data      | in        | one candidate request
//  out     | out_valid, out_stall, out_data   | out       | best index and found flag
//  cfg     | cfg_valid, cfg_ready, cfg_index, | in        | one register write request
//          | cfg_data                         |           |
//
// One candidate per cycle while in_stall is low. A last candidate reaches out_valid through the
// input register, score register (squares and sums), then compare and result register.
// The running best lives in the compare stage, which updates it when a better eligible candidate passes.
// Reset clears all control state and the running best and sets the config registers to their defaults.
// out_stall holds the result register; a last candidate waits in the score stage while the
// result is held, and input stalls once the input register behind it is also full.
module framebuffer_format_best_match_top
	import fbfbm_pkg::*;
#(
	parameter int MAX_CANDIDATES = DEFAULT_MAX_CANDIDATES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  fbfbm_in_t             in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output fbfbm_out_t            out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);

	logic [23:0] want_rgb_q;
	logic [23:0] want_ads_q;
	logic [31:0] want_accum_q;
	logic [3:0]  want_aux_q;
	logic [7:0]  want_samples_q;
	logic [2:0]  want_flags_q;
	logic [10:0] dont_care_q;

	logic              v_s1;
	fbfbm_in_t         in_s1;
	logic              v_s2;
	logic              last_s2;
	logic              elig_s2;
	logic [MISS_W-1:0]  miss_s2;
	logic [COLOR_W-1:0] color_s2;
	logic [EXTRA_W-1:0] extra_s2;

	logic [MISS_W-1:0]  best_miss_q;
	logic [COLOR_W-1:0] best_color_q;
	logic [EXTRA_W-1:0] best_extra_q;
	logic [IDX_W-1:0]   best_pos_q;
	logic               have_best_q;
	logic [CNT_W-1:0]   cnt_q;

	logic       out_valid_q;
	fbfbm_out_t out_q;

	logic out_free, s2_fire, s2_take, s1_fire, s1_take;
	logic elig, in_range, better, take_best, have_best_nx;
	logic [MISS_W-1:0]  miss;
	logic [COLOR_W-1:0] color;
	logic [EXTRA_W-1:0] extra;
	logic [IDX_W-1:0]   pos_nx;
	logic [3:0]         aux_def;

	assign out_free = !out_valid_q || !out_stall;
	assign s2_fire  = v_s2 && (!last_s2 || out_free);
	assign s2_take  = !v_s2 || s2_fire;
	assign s1_fire  = v_s1 && s2_take;
	assign s1_take  = !v_s1 || s1_fire;
	assign in_stall = !s1_take;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			want_rgb_q     <= RESET_WANT_RGB;
			want_ads_q     <= RESET_WANT_ADS;
			want_accum_q   <= '0;
			want_aux_q     <= '0;
			want_samples_q <= '0;
			want_flags_q   <= '0;
			dont_care_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WANT_RGB:     want_rgb_q     <= cfg_data[23:0];
				REG_WANT_ADS:     want_ads_q     <= cfg_data[23:0];
				REG_WANT_ACCUM:   want_accum_q   <= cfg_data[31:0];
				REG_WANT_AUX:     want_aux_q     <= cfg_data[3:0];
				REG_WANT_SAMPLES: want_samples_q <= cfg_data[7:0];
				REG_WANT_FLAGS:   want_flags_q   <= cfg_data[2:0];
				REG_DONT_CARE:    dont_care_q    <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		logic [16:0] rgb_sum;
		logic [17:0] ads_sum;
		logic [17:0] acc_sum;
		logic [15:0] sq;
		rgb_sum = '0;
		ads_sum = '0;
		acc_sum = '0;

		elig = !(want_flags_q[FLAG_STEREO] && !in_s1.format_flags[FLAG_STEREO]) &&
			(want_flags_q[FLAG_DOUBLE] == in_s1.format_flags[FLAG_DOUBLE]);

		aux_def = (want_aux_q > in_s1.aux_buffers) ? (want_aux_q - in_s1.aux_buffers) : 4'd0;
		miss = MISS_W'(aux_def)
			+ MISS_W'(!dont_care_q[DC_ALPHA] && want_ads_q[7:0] != 8'd0 &&
				in_s1.alpha_bits == 8'd0)
			+ MISS_W'(!dont_care_q[DC_DEPTH] && want_ads_q[15:8] != 8'd0 &&
				in_s1.depth_bits == 8'd0)
			+ MISS_W'(!dont_care_q[DC_STENCIL] && want_ads_q[23:16] != 8'd0 &&
				in_s1.stencil_bits == 8'd0)
			+ MISS_W'(!dont_care_q[DC_SAMPLES] && want_samples_q != 8'd0 &&
				in_s1.sample_count == 8'd0);

		sq = dont_care_q[DC_RED] ? 16'd0 : sq_diff(want_rgb_q[7:0], in_s1.red_bits);
		rgb_sum = rgb_sum + 17'(sq);
		sq = dont_care_q[DC_GREEN] ? 16'd0 : sq_diff(want_rgb_q[15:8], in_s1.green_bits);
		rgb_sum = rgb_sum + 17'(sq);
		sq = dont_care_q[DC_BLUE] ? 16'd0 : sq_diff(want_rgb_q[23:16], in_s1.blue_bits);
		color = COLOR_W'(rgb_sum) + COLOR_W'(sq);

		sq = dont_care_q[DC_ALPHA] ? 16'd0 : sq_diff(want_ads_q[7:0], in_s1.alpha_bits);
		ads_sum = ads_sum + 18'(sq);
		sq = dont_care_q[DC_DEPTH] ? 16'd0 : sq_diff(want_ads_q[15:8], in_s1.depth_bits);
		ads_sum = ads_sum + 18'(sq);
		sq = dont_care_q[DC_STENCIL] ? 16'd0 : sq_diff(want_ads_q[23:16], in_s1.stencil_bits);
		ads_sum = ads_sum + 18'(sq);
		sq = dont_care_q[DC_SAMPLES] ? 16'd0 : sq_diff(want_samples_q, in_s1.sample_count);
		ads_sum = ads_sum + 18'(sq);

		for (int k = 0; k < 4; k++) begin
			acc_sum = acc_sum + (dont_care_q[DC_ACCUM0 + k] ? 18'd0 :
				18'(sq_diff(want_accum_q[8*k +: 8], in_s1.accum_bits[8*k +: 8])));
		end

		extra = EXTRA_W'(ads_sum) + EXTRA_W'(acc_sum) +
			EXTRA_W'(want_flags_q[FLAG_SRGB] && !in_s1.format_flags[FLAG_SRGB]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s1_take) begin
				v_s1 <= in_valid;
			end
			if (s2_take) begin
				v_s2 <= s1_fire;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && s1_take) begin
			in_s1 <= in_data;
		end
		if (s1_fire) begin
			last_s2  <= in_s1.last;
			elig_s2  <= elig;
			miss_s2  <= miss;
			color_s2 <= color;
			extra_s2 <= extra;
		end
	end

	always_comb begin
		in_range = cnt_q < CNT_W'(MAX_CANDIDATES);
		better = !have_best_q || (miss_s2 < best_miss_q) ||
			((miss_s2 == best_miss_q) && ((color_s2 < best_color_q) ||
			((color_s2 == best_color_q) && (extra_s2 < best_extra_q))));
		take_best = in_range && elig_s2 && better;
		have_best_nx = have_best_q || take_best;
		pos_nx = take_best ? IDX_W'(cnt_q) : best_pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_miss_q  <= '0;
			best_color_q <= '0;
			best_extra_q <= '0;
			best_pos_q   <= '0;
			have_best_q  <= 1'b0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (s2_fire && last_s2) begin
				best_miss_q  <= '0;
				best_color_q <= '0;
				best_extra_q <= '0;
				best_pos_q   <= '0;
				have_best_q  <= 1'b0;
				cnt_q        <= '0;
			end else if (s2_fire) begin
				if (take_best) begin
					best_miss_q  <= miss_s2;
					best_color_q <= color_s2;
					best_extra_q <= extra_s2;
					best_pos_q   <= pos_nx;
					have_best_q  <= 1'b1;
				end
				if (in_range) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (s2_fire && last_s2) begin
				out_valid_q      <= 1'b1;
				out_q.found      <= have_best_nx;
				out_q.best_index <= have_best_nx ? pos_nx : '0;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.found || out_q.best_index == '0))
		else $error("result without a match carries a nonzero index");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_CANDIDATES))
		else $error("position counter passed its limit");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_fire && last_s2) |=> (!have_best_q && cnt_q == '0 && out_valid_q))
		else $error("state not cleared after the last candidate");

	a_miss_bound: assert property (@(posedge clk) disable iff (!arst_n)
		best_miss_q <= MISS_W'(19))
		else $error("kept missing count out of range");

endmodule
